### rtl/core/dhkt_pkg.sv
// Package with shared types, constants and codes for the double-hash key table.
package dhkt_pkg;

  localparam int unsigned CapacityDefault = 1024;
  localparam logic [9:0] SizeReset = 10'd127;
  localparam int unsigned MinShrinkSize = 64;

  localparam logic [1:0] TagEmpty = 2'd0;
  localparam logic [1:0] TagTomb  = 2'd1;
  localparam logic [1:0] TagLive  = 2'd2;

  localparam logic [1:0] OpLookup  = 2'd0;
  localparam logic [1:0] OpInsert  = 2'd1;
  localparam logic [1:0] OpRemove  = 2'd2;
  localparam logic [1:0] OpReplace = 2'd3;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StNotFound = 3'd1;
  localparam logic [2:0] StExists   = 3'd2;
  localparam logic [2:0] StNoFree   = 3'd3;
  localparam logic [2:0] StStale    = 3'd4;

  localparam logic [1:0] HintNone   = 2'd0;
  localparam logic [1:0] HintGrow   = 2'd1;
  localparam logic [1:0] HintShrink = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture request, start modulo reductions
    logic mod_step;   // one restoring-division step on both remainders
    logic probe_init; // index <- start
    logic rd_issue;   // issue read of current slot
    logic check;      // capture slot outcome, record first free slot
    logic advance;    // index <- index + step (mod size)
    logic wr_tag;     // write tag at write address
    logic wr_data;    // write key/hash at write address
    logic wr_value;   // write value at write address
    logic clr_step;   // clearing pass: write empty tag and advance
    logic finish;     // register result
  } dhkt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mod_done;
    logic clr_done;
    logic is_live;
    logic is_empty;
    logic match;     // hash and key equal, valid with is_live
    logic lap_end;   // next index equals start
    logic has_free;
  } dhkt_stat_t;

endpackage

### rtl/core/dhkt_ram.sv
// Generic single-port RAM with registered read.
module dhkt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

### rtl/core/dhkt_datapath.sv
// Datapath: request registers, modulo unit, probe index, slot memories, result.
module dhkt_datapath import dhkt_pkg::*; #(
  parameter int unsigned Capacity = CapacityDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  dhkt_cmd_t    cmd_i,
  output dhkt_stat_t   stat_o,
  input  logic [9:0]   table_size_i,
  input  logic [1:0]   op_i,
  input  logic [63:0]  key_i,
  input  logic [31:0]  key_hash_i,
  input  logic [31:0]  new_value_i,
  input  logic [31:0]  expected_value_i,
  output logic [2:0]   status_o,
  output logic [31:0]  found_value_o,
  output logic [9:0]   slot_index_o,
  output logic [10:0]  entry_count_o,
  output logic [1:0]   resize_hint_o,
  output logic [1:0]   op_o,
  output logic         value_eq_o
);
  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned CapLim = (Capacity < 1023) ? Capacity : 1023;

  logic [1:0]  op_q;
  logic [63:0] key_q;
  logic [31:0] hash_q, nv_q, ev_q, sh_q, val_q;
  logic [9:0]  size_q, start_q, step_q, idx_q, free_q, hit_q, rem_a_q, rem_b_q;
  logic [5:0]  mcnt_q;
  logic        has_free_q;
  logic        found_q;
  logic [10:0] count_q;
  logic [AW-1:0] clr_q;
  logic        clr_done_q;
  logic [2:0]  status_d;
  logic [31:0] found_value_d;
  logic [9:0]  slot_index_d;

  // Effective size: clamped into [3, CapLim].
  logic [9:0] eff_size;
  always_comb begin
    eff_size = table_size_i;
    if ({1'b0, eff_size} > 11'(CapLim)) eff_size = 10'(CapLim);
    if (eff_size < 10'd3) eff_size = 10'd3;
  end

  // Restoring division, one bit per step, for both moduli in parallel.
  logic [10:0] ta, tb;
  logic [9:0]  size_m2;
  assign size_m2 = size_q - 10'd2;
  assign ta = {rem_a_q, sh_q[31]};
  assign tb = {rem_b_q, sh_q[31]};

  // Next probe index.
  logic [10:0] nsum;
  logic [9:0]  nidx;
  assign nsum = {1'b0, idx_q} + {1'b0, step_q};
  assign nidx = (nsum >= {1'b0, size_q}) ? 10'(nsum - {1'b0, size_q}) : nsum[9:0];

  // Memories.
  logic [AW-1:0] addr;
  logic [1:0]  tag_rd, tag_wd;
  logic [63:0] key_rd;
  logic [31:0] hash_rd, val_rd;
  logic        tag_we;

  always_comb begin
    addr = AW'(idx_q);
    if (cmd_i.clr_step) addr = clr_q;
    else if (cmd_i.wr_tag || cmd_i.wr_data || cmd_i.wr_value) begin
      addr = (op_q == OpInsert) ? AW'(free_q) : AW'(hit_q);
    end
  end
  assign tag_we = cmd_i.wr_tag || cmd_i.clr_step;
  assign tag_wd = cmd_i.clr_step ? TagEmpty : ((op_q == OpInsert) ? TagLive : TagTomb);

  dhkt_ram #(.Width(2), .Depth(Capacity)) u_tag (
    .clk_i, .we_i(tag_we), .addr_i(addr), .wdata_i(tag_wd), .rdata_o(tag_rd));
  dhkt_ram #(.Width(64), .Depth(Capacity)) u_key (
    .clk_i, .we_i(cmd_i.wr_data), .addr_i(addr), .wdata_i(key_q), .rdata_o(key_rd));
  dhkt_ram #(.Width(32), .Depth(Capacity)) u_hash (
    .clk_i, .we_i(cmd_i.wr_data), .addr_i(addr), .wdata_i(hash_q), .rdata_o(hash_rd));
  dhkt_ram #(.Width(32), .Depth(Capacity)) u_val (
    .clk_i, .we_i(cmd_i.wr_value), .addr_i(addr), .wdata_i(nv_q), .rdata_o(val_rd));

  logic is_live;
  assign is_live = (tag_rd == TagLive);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      clr_q      <= '0;
      clr_done_q <= 1'b0;
      mcnt_q     <= '0;
      has_free_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + AW'(1);
        if (clr_q == AW'(Capacity - 1)) clr_done_q <= 1'b1;
      end
      if (cmd_i.load) begin
        mcnt_q     <= '0;
        has_free_q <= 1'b0;
      end
      if (cmd_i.mod_step) mcnt_q <= mcnt_q + 6'd1;
      // A tombstone or empty slot seen on the probe path: record the first.
      if (cmd_i.check && !is_live && !has_free_q) has_free_q <= 1'b1;
      if (cmd_i.wr_tag) begin
        if (op_q == OpInsert) begin
          if (count_q != 11'h7FF) count_q <= count_q + 11'd1;
        end else if (count_q != '0) begin
          count_q <= count_q - 11'd1;
        end
      end
    end
  end

  // Result fields from the captured probe outcome; the slot data read is no longer needed.
  always_comb begin
    status_d      = StOk;
    found_value_d = '0;
    slot_index_d  = '0;
    unique case (op_q)
      OpLookup: begin
        if (found_q) begin
          found_value_d = val_q;
          slot_index_d  = hit_q;
        end else status_d = StNotFound;
      end
      OpInsert: begin
        if (found_q) status_d = StExists;
        else if (!has_free_q) status_d = StNoFree;
        else slot_index_d = free_q;
      end
      OpRemove: begin
        if (found_q) slot_index_d = hit_q;
        else status_d = StNotFound;
      end
      OpReplace: begin
        if (!found_q) status_d = StNotFound;
        else begin
          slot_index_d = hit_q;
          if (val_q != ev_q) status_d = StStale;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_i;
      key_q   <= key_i;
      hash_q  <= key_hash_i;
      nv_q    <= new_value_i;
      ev_q    <= expected_value_i;
      sh_q    <= key_hash_i;
      size_q  <= eff_size;
      rem_a_q <= '0;
      rem_b_q <= '0;
      free_q  <= '0;
    end
    if (cmd_i.mod_step) begin
      sh_q    <= {sh_q[30:0], 1'b0};
      rem_a_q <= (ta >= {1'b0, size_q}) ? 10'(ta - {1'b0, size_q}) : ta[9:0];
      rem_b_q <= (tb >= {1'b0, size_m2}) ? 10'(tb - {1'b0, size_m2}) : tb[9:0];
    end
    if (cmd_i.probe_init) begin
      start_q <= rem_a_q;
      step_q  <= rem_b_q + 10'd1;
      idx_q   <= rem_a_q;
    end
    if (cmd_i.check) begin
      found_q <= is_live && stat_o.match;
      val_q   <= val_rd;
      if (!is_live && !has_free_q) free_q <= idx_q;
    end
    if (cmd_i.advance) idx_q <= nidx;
    if (cmd_i.rd_issue) hit_q <= idx_q;
    if (cmd_i.finish) begin
      status_o      <= status_d;
      found_value_o <= found_value_d;
      slot_index_o  <= slot_index_d;
    end
  end

  // Hint uses the count after any update; finish follows the write cycle.
  logic [12:0] c4, s3;
  logic [13:0] c8;
  assign c4 = {count_q, 2'b00};
  assign c8 = {count_q, 3'b000};
  assign s3 = 13'({size_q, 1'b0}) + 13'(size_q);
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      entry_count_o <= count_q;
      if (c4 >= s3) resize_hint_o <= HintGrow;
      else if (c8 < 14'(size_q) && size_q > 10'(MinShrinkSize)) resize_hint_o <= HintShrink;
      else resize_hint_o <= HintNone;
    end
  end

  assign stat_o.mod_done = (mcnt_q == 6'd32);
  assign stat_o.clr_done = clr_done_q;
  assign stat_o.is_live  = is_live;
  assign stat_o.is_empty = (tag_rd == TagEmpty);
  assign stat_o.match    = (hash_rd == hash_q) && (key_rd == key_q);
  assign stat_o.lap_end  = (nidx == start_q);
  assign stat_o.has_free = has_free_q;
  assign op_o       = op_q;
  assign value_eq_o = (val_rd == ev_q);
endmodule

### rtl/core/dhkt_ctrl.sv
// Controller state machine sequencing clear, modulo, probe and update.
module dhkt_ctrl import dhkt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  dhkt_stat_t  stat_i,
  input  logic [1:0]  op_i,
  input  logic        value_eq_i,
  output dhkt_cmd_t   cmd_o
);
  typedef enum logic [3:0] {
    StClear, StIdle, StMod, StInit, StRead, StCheck, StWrite, StFinal, StOut
  } state_e;

  state_e state_q;
  logic   found;
  logic   stop;
  logic   out_busy;

  assign found    = stat_i.is_live && stat_i.match;
  assign stop     = stat_i.is_empty || stat_i.lap_end;
  assign out_busy = out_valid_o && !out_ready_i;
  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      StClear: cmd_o.clr_step = 1'b1;
      StIdle:  cmd_o.load = in_valid_i;
      StMod:   cmd_o.mod_step = !stat_i.mod_done;
      StInit:  cmd_o.probe_init = 1'b1;
      StRead:  cmd_o.rd_issue = 1'b1;
      StCheck: begin
        cmd_o.check   = 1'b1;
        cmd_o.advance = !found && !stop;
      end
      StWrite: begin
        unique case (op_i)
          OpInsert:  begin cmd_o.wr_tag = 1'b1; cmd_o.wr_data = 1'b1;
                           cmd_o.wr_value = 1'b1; end
          OpRemove:  cmd_o.wr_tag = 1'b1;
          OpReplace: cmd_o.wr_value = 1'b1;
          default:   cmd_o = '0;
        endcase
      end
      StFinal: cmd_o.finish = !out_busy;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      out_valid_o <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i && state_q != StFinal) out_valid_o <= 1'b0;
      unique case (state_q)
        StClear: if (stat_i.clr_done) state_q <= StIdle;
        StIdle:  if (in_valid_i) state_q <= StMod;
        StMod:   if (stat_i.mod_done) state_q <= StInit;
        StInit:  state_q <= StRead;
        StRead:  state_q <= StCheck;
        StCheck: begin
          if (found) begin
            unique case (op_i)
              OpRemove:  state_q <= StWrite;
              OpReplace: state_q <= value_eq_i ? StWrite : StFinal;
              default:   state_q <= StFinal;
            endcase
          end else if (stop) begin
            // An insert writes when a free slot was met, this one included.
            if (op_i == OpInsert && (stat_i.has_free || !stat_i.is_live)) state_q <= StWrite;
            else state_q <= StFinal;
          end else begin
            state_q <= StRead;
          end
        end
        StWrite: state_q <= StFinal;
        StFinal: begin
          if (!out_busy) begin
            out_valid_o <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

### rtl/core/double_hash_key_table_top.sv
// Steps: modulo reduction, probe setup, a read and a check per slot probed, a table write
// if any, then the result is registered while no earlier result is still waiting to be taken.
// One operation at a time; the next is accepted in the cycle after the result is registered,
// even while it waits to be taken. After reset a clearing pass empties the tag store; no
// operation is accepted meanwhile, configuration writes are taken.
module double_hash_key_table_top import dhkt_pkg::*; #(
  parameter int unsigned Capacity = CapacityDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [9:0]  cfg_table_size_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [63:0] key_i,
  input  logic [31:0] key_hash_i,
  input  logic [31:0] new_value_i,
  input  logic [31:0] expected_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] found_value_o,
  output logic [9:0]  slot_index_o,
  output logic [10:0] entry_count_o,
  output logic [1:0]  resize_hint_o
);
  logic [9:0] table_size_q;
  dhkt_cmd_t  cmd;
  dhkt_stat_t stat;
  logic [1:0] op_cur;
  logic       value_eq;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) table_size_q <= SizeReset;
    else if (cfg_valid_i) table_size_q <= cfg_table_size_i;
  end

  dhkt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .op_i(op_cur), .value_eq_i(value_eq), .cmd_o(cmd));

  dhkt_datapath #(.Capacity(Capacity)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .table_size_i(table_size_q),
    .op_i, .key_i, .key_hash_i, .new_value_i, .expected_value_i,
    .status_o, .found_value_o, .slot_index_o, .entry_count_o, .resize_hint_o,
    .op_o(op_cur), .value_eq_o(value_eq));

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= StStale) else $error("bad status");
`endif
endmodule
